// ===== hdl/ftr_pkg.sv =====
`timescale 1ns / 1ps
// Package with shared constants, types and controller states for the tensor rotation block.
package ftr_pkg;

    localparam int FracBitsDefault = 16;
    localparam int AccW = 200;

    localparam logic [1:0] ModeLoadRot    = 2'd0;
    localparam logic [1:0] ModeLoadTensor = 2'd1;
    localparam logic [1:0] ModeStart      = 2'd2;
    localparam logic [1:0] ModeRead       = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_MUL,
        S_LIMB,
        S_ACC,
        S_ROUND,
        S_READ,
        S_OUT
    } t_state;

    typedef struct packed {
        logic       clr_acc;
        logic       fetch;
        logic       mul_init;
        logic       mul_limb;
        logic [1:0] fac;
        logic [1:0] limb;
        logic       accum;
        logic       store_out;
        logic       rd_out;
        logic [6:0] o_idx;
        logic [6:0] s_idx;
        logic       dir;
    } t_cmd;

endpackage

// ===== hdl/ftr_datapath.sv =====
`timescale 1ns / 1ps
// Datapath with stores, a shared limb multiplier, an exact accumulator and rounding.
module ftr_datapath #(
    parameter int FRAC_BITS = ftr_pkg::FracBitsDefault
) (
    input  logic              i_clk,
    input  logic              i_wr_rot,
    input  logic              i_wr_ten,
    input  logic [6:0]        i_wr_idx,
    input  logic [31:0]       i_wr_val,
    input  ftr_pkg::t_cmd     i_cmd,
    input  logic              i_rst_n,
    output logic [31:0]       o_rd_val
);
    import ftr_pkg::*;

    logic [31:0] r_rot [9];
    logic [31:0] r_ten [81];
    logic [31:0] r_out [81];
    logic [80:0] r_out_vld;

    logic [1:0] oi [4];
    logic [1:0] si [4];
    logic [31:0] r_a, r_r [4];
    logic        r_neg;
    logic [31:0] r_prod [5];
    logic [31:0] r_carry;
    logic [AccW-1:0] r_acc;
    logic [31:0] r_rd;
    logic [31:0] w_mf, w_pl, w_cin;
    logic [63:0] w_pp;
    logic [AccW-1:0] w_prod;

    function automatic logic [1:0] dig(input logic [6:0] v, input int p);
        logic [12:0] t;
        t = 13'(v);
        for (int k = 0; k < 3; k++) begin
            if (k < p) t = 13'((t * 13'd43) >> 7);
        end
        return 2'(t - ((t * 13'd43) >> 7) * 13'd3);
    endfunction

    function automatic logic [31:0] mag(input logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    always_comb begin
        for (int d = 0; d < 4; d++) begin
            oi[d] = dig(i_cmd.o_idx, 3 - d);
            si[d] = dig(i_cmd.s_idx, 3 - d);
        end
    end

    // One 32-bit limb of the running product is multiplied per cycle.
    always_comb begin
        w_mf = mag(r_r[i_cmd.fac]);
        w_pl = r_prod[{1'b0, i_cmd.limb}];
        w_cin = (i_cmd.limb == 2'd0) ? 32'd0 : r_carry;
        w_pp = {32'd0, w_pl} * {32'd0, w_mf} + {32'd0, w_cin};
        w_prod = AccW'({r_prod[4], r_prod[3], r_prod[2], r_prod[1], r_prod[0]});
    end

    logic [AccW-1:0] w_half, w_sum, w_sh;
    logic [31:0] w_sat;
    always_comb begin
        w_half = '0;
        w_half[4*FRAC_BITS-1] = 1'b1;
        w_sum = r_acc + w_half;
        w_sh = $signed(w_sum) >>> (4*FRAC_BITS);
        if ($signed(w_sh) > $signed({{(AccW-32){1'b0}}, 32'h7FFFFFFF}))
            w_sat = 32'h7FFFFFFF;
        else if ($signed(w_sh) < $signed({{(AccW-32){1'b1}}, 32'h80000000}))
            w_sat = 32'h80000000;
        else
            w_sat = w_sh[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_rot && i_wr_idx < 7'd9) r_rot[i_wr_idx[3:0]] <= i_wr_val;
        if (i_wr_ten && i_wr_idx < 7'd81) r_ten[i_wr_idx] <= i_wr_val;
        if (i_cmd.fetch) begin
            r_a <= r_ten[i_cmd.s_idx];
            for (int d = 0; d < 4; d++) begin
                r_r[d] <= i_cmd.dir ? r_rot[4'(oi[d]) * 4'd3 + 4'(si[d])]
                                    : r_rot[4'(si[d]) * 4'd3 + 4'(oi[d])];
            end
        end
        if (i_cmd.mul_init) begin
            for (int k = 0; k < 5; k++) r_prod[k] <= (k == 0) ? mag(r_a) : 32'd0;
            r_neg <= r_a[31] ^ r_r[0][31] ^ r_r[1][31] ^ r_r[2][31] ^ r_r[3][31];
        end else if (i_cmd.mul_limb) begin
            for (int k = 0; k < 5; k++) begin
                if (3'(k) == {1'b0, i_cmd.limb})
                    r_prod[k] <= w_pp[31:0];
                else if (i_cmd.limb == i_cmd.fac && 3'(k) == 3'(i_cmd.fac) + 3'd1)
                    r_prod[k] <= w_pp[63:32];
            end
            r_carry <= w_pp[63:32];
        end
        if (i_cmd.clr_acc) r_acc <= '0;
        else if (i_cmd.accum)
            r_acc <= r_neg ? r_acc - w_prod : r_acc + w_prod;
        if (i_cmd.store_out) r_out[i_cmd.o_idx] <= w_sat;
        if (i_cmd.rd_out)
            r_rd <= (i_cmd.o_idx < 7'd81 && r_out_vld[i_cmd.o_idx]) ? r_out[i_cmd.o_idx]
                                                                    : 32'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_vld <= '0;
        else if (i_cmd.store_out) r_out_vld[i_cmd.o_idx] <= 1'b1;
    end

    assign o_rd_val = r_rd;
endmodule

// ===== hdl/ftr_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine sequencing loads, the transform loop and reads.
module ftr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [1:0]    i_mode,
    input  logic [6:0]    i_idx,
    input  logic          i_dir,
    input  logic          i_out_ready,
    output logic          o_ready,
    output logic          o_out_valid,
    output logic [6:0]    o_out_idx,
    output logic          o_wr_rot,
    output logic          o_wr_ten,
    output ftr_pkg::t_cmd o_cmd
);
    import ftr_pkg::*;

    t_state r_state, n_state;
    logic [6:0] r_o, n_o, r_s, n_s;
    logic [1:0] r_f, n_f, r_l, n_l;
    logic r_dir, n_dir;
    logic w_acc;

    assign w_acc = i_valid && o_ready;
    assign o_wr_rot = w_acc && i_mode == ModeLoadRot;
    assign o_wr_ten = w_acc && i_mode == ModeLoadTensor;
    assign o_out_idx = r_o;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_o <= '0; r_s <= '0; r_f <= '0; r_l <= '0; r_dir <= 1'b0;
        end else begin
            r_state <= n_state;
            r_o <= n_o; r_s <= n_s; r_f <= n_f; r_l <= n_l; r_dir <= n_dir;
        end
    end

    always_comb begin
        n_state = r_state; n_o = r_o; n_s = r_s; n_f = r_f; n_l = r_l; n_dir = r_dir;
        o_ready = 1'b0; o_out_valid = 1'b0;
        o_cmd = '0;
        o_cmd.o_idx = r_o; o_cmd.s_idx = r_s; o_cmd.dir = r_dir;
        o_cmd.fac = r_f; o_cmd.limb = r_l;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (w_acc && i_mode == ModeStart) begin
                    n_state = S_FETCH; n_o = '0; n_s = '0; n_dir = i_dir;
                    o_cmd.clr_acc = 1'b1;
                end else if (w_acc && i_mode == ModeRead) begin
                    n_state = S_READ; n_o = i_idx;
                end
            end
            S_FETCH: begin
                o_cmd.fetch = 1'b1; n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_init = 1'b1; n_f = '0; n_l = '0; n_state = S_LIMB;
            end
            S_LIMB: begin
                o_cmd.mul_limb = 1'b1;
                if (r_l == r_f) begin
                    n_l = '0;
                    if (r_f == 2'd3) n_state = S_ACC;
                    else n_f = r_f + 2'd1;
                end else begin
                    n_l = r_l + 2'd1;
                end
            end
            S_ACC: begin
                o_cmd.accum = 1'b1;
                if (r_s == 7'd80) begin
                    n_state = S_ROUND; n_s = '0;
                end else begin
                    n_s = r_s + 7'd1; n_state = S_FETCH;
                end
            end
            S_ROUND: begin
                o_cmd.store_out = 1'b1; o_cmd.clr_acc = 1'b1;
                if (r_o == 7'd80) n_state = S_IDLE;
                else begin
                    n_o = r_o + 7'd1; n_state = S_FETCH;
                end
            end
            S_READ: begin
                o_cmd.rd_out = 1'b1; n_state = S_OUT;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

// ===== hdl/fourth_order_tensor_rotation_top.sv =====
`timescale 1ns / 1ps
// Top level of the fourth-order tensor rotation block.
// A load word is written when it is accepted, and the block stays ready.
// A read word is followed by a state that fetches the stored entry, after
// which its result word is presented until taken. A start runs 81 output
// entries times 81 source terms; each term passes through a fetch step, a
// setup step, the limb steps of a 32 by 32 bit limb multiplier that build the
// five-factor product, and an accumulate step, and each entry adds a rounding
// step, so no word is taken until the last entry has been rounded.
module fourth_order_tensor_rotation_top #(
    parameter int FRAC_BITS = ftr_pkg::FracBitsDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // entry_index[6:0], entry_value[38:7], zero
    input  logic [2:0]  s_axis_tuser,  // mode[1:0], direction[2]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata   // output_value[31:0], output_index[38:32], zero
);
    import ftr_pkg::*;

    t_cmd        w_cmd;
    logic        w_wr_rot, w_wr_ten;
    logic [6:0]  w_oidx;
    logic [31:0] w_val;

    ftr_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(s_axis_tvalid),
        .i_mode(s_axis_tuser[1:0]), .i_idx(s_axis_tdata[6:0]), .i_dir(s_axis_tuser[2]),
        .i_out_ready(m_axis_tready), .o_ready(s_axis_tready), .o_out_valid(m_axis_tvalid),
        .o_out_idx(w_oidx), .o_wr_rot(w_wr_rot), .o_wr_ten(w_wr_ten), .o_cmd(w_cmd)
    );

    ftr_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk(i_clk), .i_wr_rot(w_wr_rot), .i_wr_ten(w_wr_ten),
        .i_wr_idx(s_axis_tdata[6:0]), .i_wr_val(s_axis_tdata[38:7]),
        .i_cmd(w_cmd), .i_rst_n(i_rst_n), .o_rd_val(w_val)
    );

    assign m_axis_tdata = {1'b0, w_oidx, w_val};
endmodule
